FILE: design/two_way_sorted_merge_macros.svh
// ----------------------------------------------------------------------------
// two_way_sorted_merge_macros.svh
// Assertion helpers for the sorted merge block.
// ----------------------------------------------------------------------------
`ifndef TWO_WAY_SORTED_MERGE_MACROS_SVH
`define TWO_WAY_SORTED_MERGE_MACROS_SVH

// same-cycle implication, checked out of reset
`define TSM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define TSM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/tsm_pkg.sv
// ----------------------------------------------------------------------------
// tsm_pkg
// Shared types and constants for the two-way sorted merge block.
// ----------------------------------------------------------------------------
package tsm_pkg;

    localparam int DATA_W = 32;

    // controller -> datapath commands
    typedef struct packed {
        logic load;   // append request value (or flag a drop)
        logic prep;   // pick leading list, rewind heads
        logic step;   // emit one merged value
        logic clear;  // empty both lists and the drop flag
    } t_cmd;

    // datapath -> controller status
    typedef struct packed {
        logic both_empty;
        logic last_step;
    } t_stat;

endpackage

FILE: design/tsm_ctrl.sv
// ----------------------------------------------------------------------------
// tsm_ctrl
// Load / prepare / merge sequencer for the sorted merge block.
// ----------------------------------------------------------------------------
module tsm_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic            i_carries_value,
    input  logic            i_finish,
    input  tsm_pkg::t_stat  i_stat,
    output tsm_pkg::t_cmd   o_cmd,
    output logic            o_busy
);
    import tsm_pkg::*;

    localparam int ST_W = 2;
    localparam logic [ST_W-1:0] ST_IDLE  = 2'd0;
    localparam logic [ST_W-1:0] ST_PREP  = 2'd1;
    localparam logic [ST_W-1:0] ST_MERGE = 2'd2;

    logic [ST_W-1:0] r_state;
    logic [ST_W-1:0] n_state;
    logic            accept;

    assign o_busy = (r_state != ST_IDLE);
    assign accept = i_start && !o_busy;

    always_comb begin
        n_state     = r_state;
        o_cmd.load  = 1'b0;
        o_cmd.prep  = 1'b0;
        o_cmd.step  = 1'b0;
        o_cmd.clear = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    o_cmd.load = i_carries_value;
                    if (i_finish) begin
                        n_state = ST_PREP;
                    end
                end
            end
            ST_PREP: begin
                if (i_stat.both_empty) begin
                    o_cmd.clear = 1'b1;
                    n_state     = ST_IDLE;
                end else begin
                    o_cmd.prep = 1'b1;
                    n_state    = ST_MERGE;
                end
            end
            ST_MERGE: begin
                o_cmd.step = 1'b1;
                if (i_stat.last_step) begin
                    o_cmd.clear = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: design/tsm_datapath.sv
// ----------------------------------------------------------------------------
// tsm_datapath
// List stores, counts, merge heads, compare and result register.
// ----------------------------------------------------------------------------
module tsm_datapath #(
    parameter int LIST_DEPTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  tsm_pkg::t_cmd                     i_cmd,
    output tsm_pkg::t_stat                    o_stat,
    input  logic signed [tsm_pkg::DATA_W-1:0] i_element_value,
    input  logic                              i_list_sel,
    output logic                              o_valid,
    output logic signed [tsm_pkg::DATA_W-1:0] o_merged_value,
    output logic                              o_from_list,
    output logic                              o_last_of_run,
    output logic                              o_overflow_seen
);
    import tsm_pkg::*;

    localparam int CNT_W = $clog2(LIST_DEPTH + 1);
    localparam int IDX_W = $clog2(LIST_DEPTH);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(LIST_DEPTH);

    logic signed [DATA_W-1:0] r_store_a [LIST_DEPTH];
    logic signed [DATA_W-1:0] r_store_b [LIST_DEPTH];
    logic [CNT_W-1:0]         r_cnt_a;
    logic [CNT_W-1:0]         r_cnt_b;
    logic [CNT_W-1:0]         r_idx_a;
    logic [CNT_W-1:0]         r_idx_b;
    logic                     r_dropped;
    logic                     r_lead_b;
    logic                     r_valid;
    logic signed [DATA_W-1:0] r_value;
    logic                     r_from;
    logic                     r_last;
    logic                     r_ovf;

    logic signed [DATA_W-1:0] head_a;
    logic signed [DATA_W-1:0] head_b;
    logic                     a_left;
    logic                     b_left;
    logic                     take_a;
    logic                     wr_a;
    logic                     wr_b;

    assign head_a = r_store_a[r_idx_a[IDX_W-1:0]];
    assign head_b = r_store_b[r_idx_b[IDX_W-1:0]];
    assign a_left = (r_idx_a != r_cnt_a);
    assign b_left = (r_idx_b != r_cnt_b);

    // ties go to the leading list
    always_comb begin
        if (!a_left) begin
            take_a = 1'b0;
        end else if (!b_left) begin
            take_a = 1'b1;
        end else if (r_lead_b) begin
            take_a = (head_a < head_b);
        end else begin
            take_a = (head_a <= head_b);
        end
    end

    assign o_stat.both_empty = (r_cnt_a == '0) && (r_cnt_b == '0);
    assign o_stat.last_step  = take_a
        ? ((r_idx_a + CNT_W'(1) == r_cnt_a) && !b_left)
        : ((r_idx_b + CNT_W'(1) == r_cnt_b) && !a_left);

    assign wr_a = i_cmd.load && !i_list_sel && (r_cnt_a != FULL);
    assign wr_b = i_cmd.load &&  i_list_sel && (r_cnt_b != FULL);

    always_ff @(posedge i_clk) begin
        if (wr_a) begin
            r_store_a[r_cnt_a[IDX_W-1:0]] <= i_element_value;
        end
        if (wr_b) begin
            r_store_b[r_cnt_b[IDX_W-1:0]] <= i_element_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_a   <= '0;
            r_cnt_b   <= '0;
            r_idx_a   <= '0;
            r_idx_b   <= '0;
            r_dropped <= 1'b0;
            r_lead_b  <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            if (wr_a) begin
                r_cnt_a <= r_cnt_a + CNT_W'(1);
            end
            if (wr_b) begin
                r_cnt_b <= r_cnt_b + CNT_W'(1);
            end
            if (i_cmd.load && !wr_a && !wr_b) begin
                r_dropped <= 1'b1;
            end
            if (i_cmd.prep) begin
                r_idx_a  <= '0;
                r_idx_b  <= '0;
                r_lead_b <= (r_cnt_a != '0) && (r_cnt_b != '0)
                            && (r_store_b[0] < r_store_a[0]);
            end
            if (i_cmd.step) begin
                r_valid <= 1'b1;
                if (take_a) begin
                    r_idx_a <= r_idx_a + CNT_W'(1);
                end else begin
                    r_idx_b <= r_idx_b + CNT_W'(1);
                end
            end
            if (i_cmd.clear) begin
                r_cnt_a   <= '0;
                r_cnt_b   <= '0;
                r_idx_a   <= '0;
                r_idx_b   <= '0;
                r_dropped <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_value <= take_a ? head_a : head_b;
            r_from  <= !take_a;
            r_last  <= o_stat.last_step;
            r_ovf   <= r_dropped;
        end
    end

    assign o_valid         = r_valid;
    assign o_merged_value  = r_value;
    assign o_from_list     = r_from;
    assign o_last_of_run   = r_last;
    assign o_overflow_seen = r_ovf;

endmodule

FILE: design/two_way_sorted_merge.sv
// ----------------------------------------------------------------------------
// two_way_sorted_merge
// Loads two ascending lists, then streams out their merged ascending order.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken on a rising edge with start high and busy low. With
//   i_carries_value set, i_element_value is appended to list A or B
//   (i_list_sel); a request to a full list (LIST_DEPTH entries) is dropped
//   and remembered. Loads can be issued back to back.
//   A request with i_finish set (after its own append) starts the merge:
//   busy stays high through the prepare state and the merge. Results come
//   on o_merged_value / o_from_list / o_overflow_seen, one per cycle under
//   the o_valid strobe, the first one registered from the first merge step;
//   o_last_of_run marks the final one. The rate is set by the single
//   head compare, one value per cycle. If both lists are empty, no result
//   is sent and busy is high for one cycle. Afterwards lists and the drop
//   flag are empty again. Results cannot be held off by the receiver.
//   Synchronous reset empties both lists and clears the drop flag.
// ----------------------------------------------------------------------------
`include "two_way_sorted_merge_macros.svh"

module two_way_sorted_merge #(
    parameter int LIST_DEPTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [tsm_pkg::DATA_W-1:0] i_element_value,
    input  logic                              i_list_sel,
    input  logic                              i_carries_value,
    input  logic                              i_finish,
    output logic                              o_valid,
    output logic signed [tsm_pkg::DATA_W-1:0] o_merged_value,
    output logic                              o_from_list,
    output logic                              o_last_of_run,
    output logic                              o_overflow_seen
);
    import tsm_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    tsm_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_carries_value (i_carries_value),
        .i_finish        (i_finish),
        .i_stat          (stat),
        .o_cmd           (cmd),
        .o_busy          (busy)
    );

    tsm_datapath #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_element_value (i_element_value),
        .i_list_sel      (i_list_sel),
        .o_valid         (o_valid),
        .o_merged_value  (o_merged_value),
        .o_from_list     (o_from_list),
        .o_last_of_run   (o_last_of_run),
        .o_overflow_seen (o_overflow_seen)
    );

    `TSM_ASSERT_NEXT(a_finish_busy, i_clk, i_rst_n, start && !busy && i_finish, busy, "finish request did not start merge")
    `TSM_ASSERT_NEXT(a_load_quiet, i_clk, i_rst_n, start && !busy && !i_finish, !o_valid, "result after plain load")
    `TSM_ASSERT_NOW(a_mid_busy, i_clk, i_rst_n, o_valid && !o_last_of_run, busy, "merge ended before last result")
    `TSM_ASSERT_NEXT(a_run_gapless, i_clk, i_rst_n, o_valid && !o_last_of_run, o_valid, "gap in merged output")

endmodule
